@@ src/deadline_timer_queue_macros.svh @@
// ---------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by arst_n.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication
`define DTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dtq_pkg.sv @@
// ---------------------------------------------------------------------------
// Deadline timer queue package
// States, function codes, result kinds and register indexes.
// ---------------------------------------------------------------------------
package dtq_pkg;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_REMOVED = 3'd2;
	localparam logic [2:0] KIND_EXPIRED = 3'd3;
	localparam logic [2:0] KIND_IDLE    = 3'd4;

	localparam logic REG_WAIT_TIME = 1'b0;
	localparam logic REG_KICK      = 1'b1;

	localparam logic [11:0] WAIT_TIME_RESET = 12'd20;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RES,
		S_INS_RD,
		S_INS_EV,
		S_INS_WR,
		S_REM_RD,
		S_REM_EV,
		S_TK_RD,
		S_TK_EV,
		S_EM_RD,
		S_EM_EV,
		S_MV_RD,
		S_MV_EV,
		S_WB_RD,
		S_WB_EV
	} state_t;

endpackage

@@ src/deadline_timer_queue.sv @@
// ---------------------------------------------------------------------------
// Deadline timer queue
// Holds up to DEPTH timer entries sorted by deadline in an on-chip memory.
//
// Commands arrive on the s_ stream (tuser = func): add, remove, tick.
// Results leave on the m_ stream, one or more per command, tlast on the final.
// Configuration (wait_time at 0x0, kick_immediately at 0x4) over APB,
// written by the user only while the block is idle; the block does not enforce it.
// One command is worked at a time; each memory step is a read issue, then
// an evaluate and write. Steps per command:
//   add:    a direct write if empty, a reject if full, else a backward scan
//           that shifts every entry with a later deadline up by one
//   remove: a scan over every entry held, compacting the others
//   tick:   a scan of the due entries from the front, one emit per due entry,
//           then a move of the remaining entries and, without kick_immediately,
//           a write-back of the re-armed entries
// The result register frees the input side: a new command is taken while the
// last result still waits. If the receiver stalls, the block holds in the
// state that produces the next result. Reset empties the queue (count zero)
// and restores wait_time 20 and kick_immediately 0; no memory clearing pass.
// ---------------------------------------------------------------------------
module deadline_timer_queue #(
	parameter int DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // conn_id[15:0], seq[47:16], now[79:48]
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // conn_id_out[15:0], seq_out[47:16], entries_left[53:48]
	output logic [2:0]  m_tuser,  // kind[2:0]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dtq_pkg::*;
`include "deadline_timer_queue_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] wr_q, wr_d;
	logic [CW-1:0] due_q, due_d;
	logic [CW-1:0] nxt;
	logic [CW-1:0] wr_n;

	logic [15:0] conn_q, conn_d;
	logic [31:0] seq_q, seq_d;
	logic [31:0] now_q, now_d;
	logic [31:0] dl_q, dl_d;
	logic [2:0]  res_kind_q, res_kind_d;

	logic [11:0] wait_q;
	logic        kick_q;

	logic        out_valid_q;
	logic [2:0]  out_kind_q, out_kind_d;
	logic [15:0] out_conn_q, out_conn_d;
	logic [31:0] out_seq_q, out_seq_d;
	logic [5:0]  out_left_q, out_left_d;
	logic        out_last_q, out_last_d;
	logic        out_load;
	logic        out_free;

	logic [79:0] mem [DEPTH];
	logic [79:0] rdata_q;
	logic        mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [79:0] mem_wd;

	logic [47:0] tmem [DEPTH];
	logic [47:0] trdata_q;
	logic        tmem_we, tmem_re;
	logic [AW-1:0] tmem_wa, tmem_ra;
	logic [47:0] tmem_wd;

	logic [31:0] rd_dl;
	logic [15:0] rd_conn;
	logic [32:0] dl_sum;
	logic [31:0] dl_in;
	logic        cfg_wr;

	assign rd_dl   = rdata_q[79:48];
	assign rd_conn = rdata_q[47:32];
	assign dl_sum  = {1'b0, s_tdata[79:48]} + {21'd0, wait_q};
	assign dl_in   = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
	assign nxt     = ptr_q + CW'(1);
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_KICK) ? {31'd0, kick_q} : {20'd0, wait_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= WAIT_TIME_RESET;
			kick_q <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_KICK) kick_q <= pwdata[0];
			else wait_q <= pwdata[11:0];
		end
	end

	// entry memories
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (tmem_we) tmem[tmem_wa] <= tmem_wd;
		if (tmem_re) trdata_q <= tmem[tmem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			wr_q        <= '0;
			due_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			wr_q    <= wr_d;
			due_q   <= due_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		conn_q     <= conn_d;
		seq_q      <= seq_d;
		now_q      <= now_d;
		dl_q       <= dl_d;
		res_kind_q <= res_kind_d;
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_conn_q <= out_conn_d;
			out_seq_q  <= out_seq_d;
			out_left_q <= out_left_d;
			out_last_q <= out_last_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		wr_d       = wr_q;
		due_d      = due_q;
		conn_d     = conn_q;
		seq_d      = seq_q;
		now_d      = now_q;
		dl_d       = dl_q;
		res_kind_d = res_kind_q;
		wr_n       = wr_q;
		mem_we     = 1'b0;
		mem_wa     = '0;
		mem_wd     = '0;
		mem_re     = 1'b0;
		mem_ra     = '0;
		tmem_we    = 1'b0;
		tmem_wa    = '0;
		tmem_wd    = '0;
		tmem_re    = 1'b0;
		tmem_ra    = '0;
		out_load   = 1'b0;
		out_kind_d = KIND_IDLE;
		out_conn_d = conn_q;
		out_seq_d  = '0;
		out_left_d = 6'(count_q);
		out_last_d = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					conn_d = s_tdata[15:0];
					seq_d  = s_tdata[47:16];
					now_d  = s_tdata[79:48];
					dl_d   = dl_in;
					ptr_d  = '0;
					wr_d   = '0;
					state_d = S_RES;
					case (s_tuser)
						FUNC_ADD: begin
							if (count_q == CW'(DEPTH)) begin
								res_kind_d = KIND_FULL;
							end else if (count_q == '0) begin
								mem_we  = 1'b1;
								mem_wa  = '0;
								mem_wd  = {dl_in, s_tdata[15:0], s_tdata[47:16]};
								count_d = CW'(1);
								res_kind_d = KIND_ADDED;
							end else begin
								ptr_d   = count_q - CW'(1);
								state_d = S_INS_RD;
							end
						end
						FUNC_REMOVE: begin
							res_kind_d = KIND_REMOVED;
							if (count_q != '0) state_d = S_REM_RD;
						end
						FUNC_TICK: begin
							res_kind_d = KIND_IDLE;
							if (count_q != '0) state_d = S_TK_RD;
						end
						default: begin
							res_kind_d = KIND_IDLE;
						end
					endcase
				end
			end
			S_RES: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = res_kind_q;
					state_d    = S_IDLE;
				end
			end
			S_INS_RD: begin
				mem_re  = 1'b1;
				mem_ra  = ptr_q[AW-1:0];
				state_d = S_INS_EV;
			end
			S_INS_EV: begin
				mem_we = 1'b1;
				mem_wa = nxt[AW-1:0];
				if (rd_dl > dl_q) begin
					mem_wd = rdata_q;
					if (ptr_q == '0) begin
						state_d = S_INS_WR;
					end else begin
						ptr_d   = ptr_q - CW'(1);
						state_d = S_INS_RD;
					end
				end else begin
					mem_wd     = {dl_q, conn_q, seq_q};
					count_d    = count_q + CW'(1);
					res_kind_d = KIND_ADDED;
					state_d    = S_RES;
				end
			end
			S_INS_WR: begin
				mem_we     = 1'b1;
				mem_wa     = '0;
				mem_wd     = {dl_q, conn_q, seq_q};
				count_d    = count_q + CW'(1);
				res_kind_d = KIND_ADDED;
				state_d    = S_RES;
			end
			S_REM_RD: begin
				mem_re  = 1'b1;
				mem_ra  = ptr_q[AW-1:0];
				state_d = S_REM_EV;
			end
			S_REM_EV: begin
				if (rd_conn != conn_q) begin
					mem_we = 1'b1;
					mem_wa = wr_q[AW-1:0];
					mem_wd = rdata_q;
					wr_n   = wr_q + CW'(1);
				end
				wr_d = wr_n;
				if (nxt == count_q) begin
					count_d    = wr_n;
					res_kind_d = KIND_REMOVED;
					state_d    = S_RES;
				end else begin
					ptr_d   = nxt;
					state_d = S_REM_RD;
				end
			end
			S_TK_RD: begin
				mem_re  = 1'b1;
				mem_ra  = ptr_q[AW-1:0];
				state_d = S_TK_EV;
			end
			S_TK_EV: begin
				if (ptr_q == '0 && !(rd_dl < now_q)) begin
					res_kind_d = KIND_IDLE;
					state_d    = S_RES;
				end else if (rd_dl <= now_q) begin
					tmem_we = 1'b1;
					tmem_wa = ptr_q[AW-1:0];
					tmem_wd = rdata_q[47:0];
					due_d   = nxt;
					if (nxt == count_q) begin
						ptr_d   = '0;
						state_d = S_EM_RD;
					end else begin
						ptr_d   = nxt;
						state_d = S_TK_RD;
					end
				end else begin
					due_d   = ptr_q;
					ptr_d   = '0;
					state_d = S_EM_RD;
				end
			end
			S_EM_RD: begin
				tmem_re = 1'b1;
				tmem_ra = ptr_q[AW-1:0];
				state_d = S_EM_EV;
			end
			S_EM_EV: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = KIND_EXPIRED;
					out_conn_d = trdata_q[47:32];
					out_seq_d  = trdata_q[31:0];
					out_left_d = kick_q ? 6'(count_q - CW'(1) - ptr_q) : 6'(count_q);
					out_last_d = (nxt == due_q);
					if (nxt == due_q) begin
						ptr_d = due_q;
						if (due_q == count_q) begin
							if (kick_q) begin
								count_d = '0;
								state_d = S_IDLE;
							end else begin
								wr_d    = '0;
								ptr_d   = '0;
								state_d = S_WB_RD;
							end
						end else begin
							state_d = S_MV_RD;
						end
					end else begin
						ptr_d   = nxt;
						state_d = S_EM_RD;
					end
				end
			end
			S_MV_RD: begin
				mem_re  = 1'b1;
				mem_ra  = ptr_q[AW-1:0];
				state_d = S_MV_EV;
			end
			S_MV_EV: begin
				if (kick_q || rd_dl <= dl_q) begin
					mem_we = 1'b1;
					mem_wa = AW'(ptr_q - due_q);
					mem_wd = rdata_q;
					if (nxt == count_q) begin
						if (kick_q) begin
							count_d = count_q - due_q;
							state_d = S_IDLE;
						end else begin
							wr_d    = count_q - due_q;
							ptr_d   = '0;
							state_d = S_WB_RD;
						end
					end else begin
						ptr_d   = nxt;
						state_d = S_MV_RD;
					end
				end else begin
					wr_d    = ptr_q - due_q;
					ptr_d   = '0;
					state_d = S_WB_RD;
				end
			end
			S_WB_RD: begin
				tmem_re = 1'b1;
				tmem_ra = ptr_q[AW-1:0];
				state_d = S_WB_EV;
			end
			S_WB_EV: begin
				mem_we = 1'b1;
				mem_wa = AW'(wr_q + ptr_q);
				mem_wd = {dl_q, trdata_q};
				if (nxt == due_q) begin
					state_d = S_IDLE;
				end else begin
					ptr_d   = nxt;
					state_d = S_WB_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_left_q, out_seq_q, out_conn_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	`DTQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`DTQ_ASSERT_NEXT(a_full_reject, s_tvalid && s_tready && s_tuser == FUNC_ADD && count_q == CW'(DEPTH), state_q == S_RES && res_kind_q == KIND_FULL, "add to full store not rejected")
	`DTQ_ASSERT_NOW(a_emit_range, state_q == S_EM_EV, ptr_q < due_q && due_q <= count_q, "emit index out of range")
	`DTQ_ASSERT_NOW(a_move_range, state_q == S_MV_EV, ptr_q < count_q && ptr_q >= due_q, "move index out of range")

endmodule
